// ===== rtl/core/sha1sh_pkg.sv =====
`timescale 1ns / 1ps

package sha1sh_pkg;

    // widths of the stream fields and internal words
    localparam int ByteW     = 8;
    localparam int WordW     = 32;
    localparam int BlockW    = 512;
    localparam int CountW    = 64;
    localparam int FillW     = 6;
    localparam int IdxW      = 3;
    localparam int RoundW    = 7;
    localparam int ChainN    = 5;

    // fill positions that steer padding
    localparam logic [FillW-1:0] FillLast   = 6'd63;
    localparam logic [FillW-1:0] FillPreLen = 6'd55;

    // padding byte that opens the tail of a message
    localparam logic [ByteW-1:0] PadByte = 8'h80;

    // round phase codes, one for each group of twenty rounds
    typedef enum logic [1:0] {
        PH_CH  = 2'd0,
        PH_P1  = 2'd1,
        PH_MAJ = 2'd2,
        PH_P3  = 2'd3
    } phase_t;

    // source of a byte written into the block buffer
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic            put;
        byte_src_t       src;
        logic            count;
        logic [IdxW-1:0] len_idx;
        logic            round;
        logic            round_first;
        phase_t          phase;
        logic            fold;
        logic [IdxW-1:0] word_sel;
        logic            reload;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic fill_wrap;
        logic fill_pre_len;
    } sts_t;

    // round constant for each phase
    function automatic logic [WordW-1:0] round_k(input phase_t ph);
        logic [WordW-1:0] k;
        unique case (ph)
            PH_CH:   k = 32'h5A827999;
            PH_P1:   k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            PH_P3:   k = 32'hCA62C1D6;
            default: k = 32'h5A827999;
        endcase
        return k;
    endfunction

    // initial chaining value for each word
    function automatic logic [WordW-1:0] init_word(input logic [IdxW-1:0] idx);
        logic [WordW-1:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/sha1sh_datapath.sv =====
`timescale 1ns / 1ps

module sha1sh_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sha1sh_pkg::cmd_t               cmd,
    input  logic [sha1sh_pkg::ByteW-1:0]   data_byte,
    output sha1sh_pkg::sts_t               sts,
    output logic [sha1sh_pkg::WordW-1:0]   digest_word
);
    import sha1sh_pkg::*;

    logic [BlockW-1:0] blk_reg;
    logic [BlockW-1:0] blk_next;
    logic [FillW-1:0]  fill_reg;
    logic [FillW-1:0]  fill_next;
    logic [CountW-1:0] bit_cnt_reg;
    logic [CountW-1:0] bit_cnt_next;
    logic [WordW-1:0]  chain_reg [ChainN];
    logic [WordW-1:0]  chain_next [ChainN];
    logic [WordW-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WordW-1:0]  a_next, b_next, c_next, d_next, e_next;

    logic [WordW-1:0]  a_in, b_in, c_in, d_in, e_in;
    logic [WordW-1:0]  f_val;
    logic [WordW-1:0]  t_val;
    logic [WordW-1:0]  w_cur;
    logic [WordW-1:0]  w_mix;
    logic [WordW-1:0]  w_new;
    logic [ByteW-1:0]  byte_val;
    logic [ByteW-1:0]  len_byte;

    // message length byte, most significant first
    assign len_byte = bit_cnt_reg[{~cmd.len_idx, 3'b000} +: ByteW];

    // byte written into the block buffer
    always_comb
    begin
        case (cmd.src)
            SRC_DATA: byte_val = data_byte;
            SRC_PAD:  byte_val = PadByte;
            SRC_ZERO: byte_val = '0;
            default:  byte_val = len_byte;
        endcase
    end

    // round inputs: the first round starts from the chaining value
    assign a_in = cmd.round_first ? chain_reg[0] : a_reg;
    assign b_in = cmd.round_first ? chain_reg[1] : b_reg;
    assign c_in = cmd.round_first ? chain_reg[2] : c_reg;
    assign d_in = cmd.round_first ? chain_reg[3] : d_reg;
    assign e_in = cmd.round_first ? chain_reg[4] : e_reg;

    // schedule window: word 0 is the current round word
    assign w_cur = blk_reg[511:480];
    assign w_mix = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
    assign w_new = {w_mix[WordW-2:0], w_mix[WordW-1]};

    // round function
    always_comb
    begin
        unique case (cmd.phase)
            PH_CH:   f_val = (b_in & (c_in ^ d_in)) ^ d_in;
            PH_MAJ:  f_val = (b_in & c_in) | ((b_in | c_in) & d_in);
            default: f_val = b_in ^ c_in ^ d_in;
        endcase
    end

    assign t_val = {a_in[WordW-6:0], a_in[WordW-1:WordW-5]} + f_val + e_in
                 + round_k(cmd.phase) + w_cur;

    // next state of the working variables
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (cmd.round)
        begin
            a_next = t_val;
            b_next = a_in;
            c_next = {b_in[1:0], b_in[WordW-1:2]};
            d_next = c_in;
            e_next = d_in;
        end
    end

    // block buffer, fill and length
    always_comb
    begin
        blk_next     = blk_reg;
        fill_next    = fill_reg;
        bit_cnt_next = bit_cnt_reg;
        if (cmd.put)
        begin
            blk_next  = {blk_reg[BlockW-ByteW-1:0], byte_val};
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.round)
        begin
            blk_next = {blk_reg[BlockW-WordW-1:0], w_new};
        end
        if (cmd.count)
        begin
            bit_cnt_next = bit_cnt_reg + CountW'(ByteW);
        end
        if (cmd.reload)
        begin
            fill_next    = '0;
            bit_cnt_next = '0;
        end
    end

    // chaining value: fold after the rounds, reload after the digest
    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
        else if (cmd.reload)
        begin
            for (int i = 0; i < ChainN; i++)
            begin
                chain_next[i] = init_word(IdxW'(i));
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            bit_cnt_reg <= '0;
            for (int i = 0; i < ChainN; i++)
            begin
                chain_reg[i] <= init_word(IdxW'(i));
            end
        end
        else
        begin
            fill_reg    <= fill_next;
            bit_cnt_reg <= bit_cnt_next;
            chain_reg   <= chain_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign sts.fill_wrap    = (fill_reg == FillLast);
    assign sts.fill_pre_len = (fill_reg == FillPreLen);

    // digest word selection
    always_comb
    begin
        case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

`ifndef SYNTHESIS
    // buffer never takes a byte and a schedule shift together
    a_put_round_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.put && cmd.round))
        else $error("byte write during compression");

    // compression starts only on a full block
    a_first_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_first |-> (fill_reg == '0))
        else $error("compression started on a partial block");

    // length moves only when counted or cleared
    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.count && !cmd.reload) |=> $stable(bit_cnt_reg))
        else $error("bit count changed without a command");
`endif

endmodule

// ===== rtl/core/sha1sh_ctrl.sv =====
`timescale 1ns / 1ps

module sha1sh_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          has_byte,
    input  logic                          last,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          final_word,
    input  sha1sh_pkg::sts_t              sts,
    output sha1sh_pkg::cmd_t              cmd
);
    import sha1sh_pkg::*;

    localparam logic [RoundW-1:0] RoundLast = 7'd79;
    localparam logic [RoundW-1:0] RoundP1   = 7'd20;
    localparam logic [RoundW-1:0] RoundMaj  = 7'd40;
    localparam logic [RoundW-1:0] RoundP3   = 7'd60;
    localparam logic [IdxW-1:0]   WordLast  = 3'd4;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_FOLD  = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_LEN   = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [RoundW-1:0] round_cnt_reg, round_cnt_next;
    logic [IdxW-1:0]   len_idx_reg, len_idx_next;
    logic [IdxW-1:0]   word_idx_reg, word_idx_next;
    logic              first_pad_reg, first_pad_next;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_cnt_next = round_cnt_reg;
        len_idx_next   = len_idx_reg;
        word_idx_next  = word_idx_reg;
        first_pad_next = first_pad_reg;
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd            = '0;
        cmd.src        = SRC_DATA;
        cmd.phase      = PH_CH;
        cmd.len_idx    = len_idx_reg;
        cmd.word_sel   = word_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.put   = has_byte;
                    cmd.count = has_byte;
                    if (last)
                    begin
                        first_pad_next = 1'b1;
                    end
                    if (has_byte && sts.fill_wrap)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = last ? ST_PAD : ST_IDLE;
                    end
                    else if (last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.put        = 1'b1;
                cmd.src        = first_pad_reg ? SRC_PAD : SRC_ZERO;
                first_pad_next = 1'b0;
                if (sts.fill_wrap)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD;
                end
                else if (sts.fill_pre_len)
                begin
                    state_next   = ST_LEN;
                    len_idx_next = '0;
                end
            end
            ST_LEN:
            begin
                cmd.put      = 1'b1;
                cmd.src      = SRC_LEN;
                len_idx_next = len_idx_reg + 1'b1;
                if (sts.fill_wrap)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                cmd.round       = 1'b1;
                cmd.round_first = (round_cnt_reg == '0);
                if (round_cnt_reg < RoundP1)
                begin
                    cmd.phase = PH_CH;
                end
                else if (round_cnt_reg < RoundMaj)
                begin
                    cmd.phase = PH_P1;
                end
                else if (round_cnt_reg < RoundP3)
                begin
                    cmd.phase = PH_MAJ;
                end
                else
                begin
                    cmd.phase = PH_P3;
                end
                round_cnt_next = round_cnt_reg + 1'b1;
                if (round_cnt_reg == RoundLast)
                begin
                    round_cnt_next = '0;
                    state_next     = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold      = 1'b1;
                word_idx_next = '0;
                state_next    = ret_reg;
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (word_idx_reg == WordLast)
                    begin
                        cmd.reload = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign final_word = (word_idx_reg == WordLast);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_cnt_reg <= '0;
            len_idx_reg   <= '0;
            word_idx_reg  <= '0;
            first_pad_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_cnt_reg <= round_cnt_next;
            len_idx_reg   <= len_idx_next;
            word_idx_reg  <= word_idx_next;
            first_pad_reg <= first_pad_next;
        end
    end

`ifndef SYNTHESIS
    // input and output sides never open together
    a_side_excl: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input taken while digest pending");

    // round counter stays within the eighty rounds
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_cnt_reg <= RoundLast)
        else $error("round counter out of range");

    // the digest appears only straight after a fold
    a_emit_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && ($past(state_reg) != ST_EMIT))
            |-> ($past(state_reg) == ST_FOLD))
        else $error("digest without a completed block");

    // word index stays within the digest
    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (word_idx_reg <= WordLast))
        else $error("digest word index out of range");
`endif

endmodule

// ===== rtl/core/sha1_stream_hasher.sv =====
`timescale 1ns / 1ps

// channel | direction | tdata             | tuser          | tlast
// s_*     | in        | [7:0] data_byte   | [0] has_byte   | last
// m_*     | out       | [31:0] digest_word| [2:0] word_idx | final_word
//
// a byte is taken while idle; every 64th byte starts a compression (80 rounds
// through one shared round unit, then the fold) before more input is taken
// a last transfer pads one byte a cycle barring compression, compresses once
// or twice, then holds the five digest words on m_* until each is taken
// input is not taken while compressing, padding or emitting the digest
// rst_n is asynchronous; it reloads the initial chaining value and clears
// the fill and length counters

module sha1_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import sha1sh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    sha1sh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .has_byte   (s_tuser),
        .last       (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .final_word (m_tlast),
        .sts        (sts),
        .cmd        (cmd)
    );

    // block buffer, round unit and chaining value
    sha1sh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .sts         (sts),
        .digest_word (m_tdata)
    );

    assign m_tuser = cmd.word_sel;

endmodule

// ===== tb/sv/sha1_stream_hasher_tb.sv =====
`timescale 1ns / 1ps

module sha1_stream_hasher_tb;

    import sha1sh_pkg::*;

    // one expected digest transfer on the output stream
    typedef struct {
        logic [WordW-1:0] word;
        logic [2:0]       idx;
        logic             fin;
    } digest_beat_t;

    // bit-exact sha-1 of the byte stream and the digest words still due
    class sha1_digest_board;

        localparam logic [5:0] LenOffset = 6'd56;

        logic [WordW-1:0] chain [5];
        logic [WordW-1:0] block_buf [16];
        logic [5:0]       fill;
        logic [63:0]      length_bits;
        digest_beat_t     words_due [$];
        int               mismatches;

        function new();
            mismatches = 0;
            foreach (block_buf[i])
                block_buf[i] = '0;
            reload();
        endfunction

        function void reload();
            chain = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
            fill = '0;
            length_bits = '0;
        endfunction

        // 80 rounds over the current block, folded into the chaining words
        function void compress();
            logic [WordW-1:0] w [16];
            logic [WordW-1:0] a, b, c, d, e, f, k, t, x;
            w = block_buf;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++)
            begin
                // message schedule kept in a sixteen-word ring
                if (r >= 16)
                begin
                    x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
                    w[r % 16] = {x[30:0], x[31]};
                end
                if (r < 20)
                begin
                    f = (b & (c ^ d)) ^ d;
                    k = 32'h5A827999;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | ((b | c) & d);
                    k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // big-endian packing; a full block triggers compression
        function void put_byte(logic [7:0] v);
            int         sh;
            logic [3:0] word_no;
            word_no = fill[5:2];
            sh = (3 - fill[1:0]) * 8;
            if (fill[1:0] == 2'd0)
                block_buf[word_no] = {24'd0, v} << sh;
            else
                block_buf[word_no] |= {24'd0, v} << sh;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress();
        endfunction

        // accepted input transfer: absorb the byte, finish the message on last
        function void note_transfer(logic [7:0] d, logic hb, logic lst);
            logic [63:0]  len;
            digest_beat_t beat;
            if (hb)
            begin
                put_byte(d);
                length_bits += 64'd8;
            end
            if (!lst)
                return;
            len = length_bits;
            put_byte(PadByte);
            while (fill != LenOffset)
                put_byte(8'h00);
            for (int i = 0; i < 8; i++)
                put_byte(len[63 - 8 * i -: 8]);
            for (int i = 0; i < 5; i++)
            begin
                beat.word = chain[i];
                beat.idx = 3'(i);
                beat.fin = (i == 4);
                words_due.push_back(beat);
            end
            reload();
        endfunction

        // accepted output transfer against the oldest outstanding word
        function void check_word(logic [WordW-1:0] w, logic [2:0] idx, logic fin);
            digest_beat_t due_beat;
            if (words_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: digest word %h index %0d arrived with nothing outstanding",
                         $time, w, idx);
                return;
            end
            due_beat = words_due.pop_front();
            if (w !== due_beat.word)
            begin
                mismatches++;
                $display("%0t: digest_word expected %h actual %h", $time, due_beat.word, w);
            end
            if (idx !== due_beat.idx)
            begin
                mismatches++;
                $display("%0t: word_index expected %0d actual %0d", $time, due_beat.idx, idx);
            end
            if (fin !== due_beat.fin)
            begin
                mismatches++;
                $display("%0t: final_word expected %b actual %b", $time, due_beat.fin, fin);
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction

    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sha1_digest_board board = new();
    int               items_sent = 0;
    bit               src_burst = 1'b0;

    sha1_stream_hasher DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // one input transfer, judged from values settled before the edge
    task automatic send_item(input logic [7:0] d, input logic hb, input logic lst);
        int   gap;
        logic taken;
        gap = src_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= hb;
        s_tlast  <= lst;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        board.note_transfer(d, hb, lst);
        if (hb || lst)
            items_sent++;
    endtask

    // message of random bytes with stray empty transfers mixed in
    task automatic send_message(input int n);
        logic [7:0] d;
        bit         split;
        split = (n == 0) || ($urandom_range(0, 2) == 0);
        src_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            d = 8'($urandom_range(0, 255));
            send_item(d, 1'b1, (i == n - 1) && !split);
        end
        if (split)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // output side: stalls of random length with bursts of steady readiness
    initial
    begin
        int n;
        forever
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                n = pick_gap();
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // output transfers, checked at the falling edge ahead of the taking edge
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            board.check_word(m_tdata, m_tuser, m_tlast);
    end

    // guard against a hang
    initial
    begin
        #(64'd20_000_000);
        $display("sha1_stream_hasher regression: fail");
        $finish;
    end

    initial
    begin
        int drain;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: ignored transfer, empty message, "abc", single extremes
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // two empty messages back to back
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        // mixed extremes with a stray empty transfer inside the message
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);

        // lengths around the padding and block boundaries
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);

        // random messages, mostly short
        while (items_sent < 360)
        begin
            case ($urandom_range(0, 9))
                0:       send_message($urandom_range(54, 66));
                1, 2:    send_message($urandom_range(0, 3));
                default: send_message($urandom_range(1, 24));
            endcase
        end
        s_tvalid <= 1'b0;

        // drain outstanding digests, then allow stray output to show
        while (board.pending() != 0)
            @(posedge clk);
        for (drain = 0; drain < 300; drain++)
            @(posedge clk);

        if (board.mismatches == 0)
            $display("sha1_stream_hasher regression: pass");
        else
            $display("sha1_stream_hasher regression: fail");
        $finish;
    end

endmodule
